[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("Assertion failed.");

// Concurrent assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("Assertion failed.");

`endif

[rtl/lpvn_pkg.sv]
// Types and constants of the vector normalizer.
// Used by the top level and the checker; depends on nothing.
package lpvn_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 37;
    localparam int FRAC_STEPS  = 15;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] normalized;
        logic                       last_out;
    } t_out_item;

endpackage

[rtl/lpvn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lpvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lp_vector_normalizer.sv]
// Top level of the L1 / L2 vector normalizer.
// Depends on lpvn_pkg and lpvn_ram.
//
// Samples of one vector arrive as transfers on the input channel, the last one
// flagged by last_in. Each sample passes through the transfer and then an
// accumulate state that adds its magnitude (L1) or its square (L2) to the
// accumulator. o_in_ready is high only while the block is idle, between
// samples and between vectors. After the last sample the norm is formed:
// taken from the accumulator for L1, by square root iteration for L2. Then
// each stored sample is read from the element RAM, compared against the norm
// and divided in 15 restoring steps, one per cycle, on the compare-subtract
// unit that the square root also uses. The division is skipped when the norm
// is zero or the quotient saturates. o_out_valid holds with stable data while
// the receiver stalls; the next division starts once the transfer completes.
// Samples beyond MAX_LEN are dropped; last_in on them still ends the vector.
// Synchronous reset empties the vector, selects L2 and returns to idle; the
// element RAM needs no clearing. i_cfg_we writes the norm order at once.
module lp_vector_normalizer #(
    parameter int MAX_LEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpvn_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpvn_pkg::t_out_item o_out_data
);
    import lpvn_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
    localparam int STEP_W = $clog2(FRAC_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_SQRT  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            r_state, n_state;
    logic                  r_order, n_order;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [SAMPLE_W-1:0]   r_mag, n_mag;
    logic                  r_keep, n_keep;
    logic                  r_last, n_last;
    logic                  r_mode, n_mode;
    logic [ACC_W-1:0]      r_norm, n_norm;
    logic [ACC_W-1:0]      r_root, n_root;
    logic [ACC_W-1:0]      r_bit, n_bit;
    logic [ACC_W-1:0]      r_rem, n_rem;
    logic [FRAC_STEPS-1:0] r_quo, n_quo;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_neg, n_neg;
    t_out_item             r_out, n_out;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  ram_we;
    logic [SAMPLE_W-1:0]   rd_data;
    logic [SAMPLE_W-1:0]   rd_mag;
    logic [2*SAMPLE_W-1:0] mag_sq;
    logic [ACC_W-1:0]      acc_sum;
    logic [ACC_W:0]        u_a, u_b, u_diff;
    logic                  u_borrow;
    logic                  u_ge;
    logic [FRAC_STEPS-1:0] quo_next;
    logic [SAMPLE_W-1:0]   quo_ext;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;
    assign ram_we   = in_xfer && (r_cnt != MAX_CNT);

    lpvn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_mag  = rd_data[SAMPLE_W-1] ? (~rd_data + SAMPLE_W'(1)) : rd_data;
    assign mag_sq  = r_mag * r_mag;
    assign acc_sum = r_mode ? (r_acc + ACC_W'(mag_sq)) : (r_acc + ACC_W'(r_mag));

    always_comb begin
        unique case (r_state)
            S_SQRT: begin
                u_a = {1'b0, r_rem};
                u_b = {1'b0, r_root} + {1'b0, r_bit};
            end
            S_CHECK: begin
                u_a = (ACC_W + 1)'(rd_mag);
                u_b = {1'b0, r_norm};
            end
            S_DIV: begin
                u_a = {r_rem, 1'b0};
                u_b = {1'b0, r_norm};
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end

    assign {u_borrow, u_diff} = {1'b0, u_a} - {1'b0, u_b};
    assign u_ge     = !u_borrow;
    assign quo_next = {r_quo[FRAC_STEPS-2:0], u_ge};
    assign quo_ext  = {1'b0, quo_next};

    always_comb begin
        n_state = r_state;
        n_order = i_cfg_we ? i_cfg_wdata : r_order;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mag   = r_mag;
        n_keep  = r_keep;
        n_last  = r_last;
        n_mode  = r_mode;
        n_norm  = r_norm;
        n_root  = r_root;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mag   = i_in_data.sample[SAMPLE_W-1]
                            ? (~i_in_data.sample + SAMPLE_W'(1)) : i_in_data.sample;
                    n_keep  = ram_we;
                    n_last  = i_in_data.last_in;
                    n_mode  = r_order;
                    n_cnt   = ram_we ? (r_cnt + CNT_W'(1)) : r_cnt;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_keep) begin
                    n_acc = acc_sum;
                end
                n_idx = '0;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_mode) begin
                    n_rem   = r_keep ? acc_sum : r_acc;
                    n_root  = '0;
                    n_bit   = {1'b1, {(ACC_W-1){1'b0}}};
                    n_state = S_SQRT;
                end else begin
                    n_norm  = r_keep ? acc_sum : r_acc;
                    n_state = S_READ;
                end
            end
            S_SQRT: begin
                if (u_ge) begin
                    n_rem  = u_diff[ACC_W-1:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_norm  = u_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_neg          = rd_data[SAMPLE_W-1];
                n_out.last_out = (r_idx + CNT_W'(1)) == r_cnt;
                n_rem          = ACC_W'(rd_mag);
                n_quo          = '0;
                n_step         = '0;
                if (r_norm == '0) begin
                    n_out.normalized = '0;
                    n_state          = S_OUT;
                end else if (u_ge) begin
                    n_out.normalized = rd_data[SAMPLE_W-1]
                                     ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_W-1){1'b1}}};
                    n_state          = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = u_ge ? u_diff[ACC_W-1:0] : {r_rem[ACC_W-2:0], 1'b0};
                n_quo  = quo_next;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(FRAC_STEPS - 1)) begin
                    n_out.normalized = r_neg ? (~quo_ext + SAMPLE_W'(1)) : quo_ext;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_out.last_out) begin
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= 1'b1;
            r_cnt   <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
        end
        r_mag  <= n_mag;
        r_keep <= n_keep;
        r_last <= n_last;
        r_mode <= n_mode;
        r_norm <= n_norm;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

[rtl/lpvn_checker.sv]
// Port-level checks of the vector normalizer, bound to the top level.
// Depends on lpvn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpvn_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lpvn_pkg::t_out_item o_out_data
);
    import lpvn_pkg::*;

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
    `ASSERT_RST(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `ASSERT_RST(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind lp_vector_normalizer lpvn_checker u_lpvn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[test/lp_vector_normalizer_tb.sv]
// Self-checking testbench for lp_vector_normalizer: L1 and L2 normalization of Q8.8 vectors.
// Depends on lpvn_pkg and the lp_vector_normalizer RTL; drives random and directed vectors
// and compares every output transfer against a built-in fixed-point predictor.
`timescale 1ns / 1ps

module lp_vector_normalizer_tb;
    import lpvn_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int ITEM_TARGET    = 270;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDLE_PERCENT   = 13;
    localparam int CALM_FIRST     = 120;
    localparam int CALM_LAST      = 180;
    localparam bit ORDER_L1       = 1'b0;
    localparam bit ORDER_L2       = 1'b1;

    typedef struct {
        bit       is_cfg;
        bit       cfg_val;
        bit       calm;
        t_in_item item;
    } t_send_entry;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      cfg_we_r    = 1'b0;
    logic      cfg_wdata_r = 1'b0;
    logic      in_valid_r  = 1'b0;
    t_in_item  in_data_r   = '0;
    logic      out_ready_r = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_send_entry send_queue[$];
    t_out_item   norm_results_q[$];

    // Predictor state.
    bit          order_copy = ORDER_L2;
    logic [15:0] elem_store [MAX_LEN];
    logic [36:0] norm_acc   = '0;
    int          elem_cnt   = 0;

    bit calm_r         = 1'b0;
    int settle_cnt     = 0;
    int stall_cycles   = 0;
    int err_cnt        = 0;
    int results_seen   = 0;
    int vectors_l1     = 0;
    int vectors_l2     = 0;
    int dropped_cnt    = 0;
    int item_total     = 0;

    lp_vector_normalizer #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we_r),
        .i_cfg_wdata(cfg_wdata_r),
        .i_in_valid (in_valid_r),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data_r),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready_r),
        .o_out_data (o_out_data)
    );

    function automatic logic [16:0] magnitude(logic [15:0] raw);
        return raw[15] ? 17'(17'h10000 - {1'b0, raw}) : {1'b0, raw};
    endfunction

    function automatic logic [36:0] floor_sqrt(logic [36:0] v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 18; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(v)) begin
                root = trial;
            end
        end
        return 37'(root);
    endfunction

    function automatic logic signed [15:0] scale_sample(logic [15:0] raw, logic [36:0] norm);
        logic [47:0] q;
        if (norm == '0) begin
            return '0;
        end
        q = ({31'b0, magnitude(raw)} << 15) / {11'b0, norm};
        if (raw[15]) begin
            if (q > 48'd32768) begin
                q = 48'd32768;
            end
            return -16'(q);
        end
        if (q > 48'd32767) begin
            q = 48'd32767;
        end
        return 16'(q);
    endfunction

    task automatic predict_vector_step(input t_in_item it);
        logic [16:0] mag;
        logic [36:0] norm;
        t_out_item   res;
        if (elem_cnt < MAX_LEN) begin
            elem_store[elem_cnt] = it.sample;
            elem_cnt++;
            mag = magnitude(it.sample);
            if (order_copy == ORDER_L1) begin
                norm_acc = norm_acc + 37'(mag);
            end else begin
                norm_acc = norm_acc + 37'(mag) * 37'(mag);
            end
        end else begin
            dropped_cnt++;
        end
        if (it.last_in) begin
            if (order_copy == ORDER_L1) begin
                norm = norm_acc;
                vectors_l1++;
            end else begin
                norm = floor_sqrt(norm_acc);
                vectors_l2++;
            end
            for (int k = 0; k < elem_cnt; k++) begin
                res.normalized = scale_sample(elem_store[k], norm);
                res.last_out   = (k == elem_cnt - 1);
                norm_results_q.push_back(res);
            end
            norm_acc = '0;
            elem_cnt = 0;
        end
    endtask

    task automatic note_failure(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [15:0] random_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 16'($urandom);
            5, 6, 7: begin
                v = 16'($urandom_range(0, 1023));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    task automatic push_sample(input logic [15:0] s, input bit last);
        t_send_entry e;
        e.is_cfg       = 1'b0;
        e.cfg_val      = 1'b0;
        e.calm         = (item_total >= CALM_FIRST) && (item_total <= CALM_LAST);
        e.item.sample  = s;
        e.item.last_in = last;
        send_queue.push_back(e);
        item_total++;
    endtask

    task automatic push_cfg(input bit order);
        t_send_entry e;
        e.is_cfg  = 1'b1;
        e.cfg_val = order;
        e.calm    = (item_total >= CALM_FIRST) && (item_total <= CALM_LAST);
        e.item    = '0;
        send_queue.push_back(e);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus: directed vectors first, the first of them under the reset mode, then random vectors.
    initial begin : stim_proc
        int vec_no;
        int len;
        bit zero_vec;

        push_sample(16'h0100, 1'b1);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0001, 1'b1);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_cfg(ORDER_L1);
        push_sample(16'h0300, 1'b0);
        push_sample(16'hFD00, 1'b0);
        push_sample(16'h0100, 1'b1);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b1);
        // The norm order changes in the middle of a vector, both ways.
        push_sample(16'h0200, 1'b0);
        push_cfg(ORDER_L2);
        push_sample(16'h0200, 1'b0);
        push_sample(16'hFF00, 1'b1);
        push_sample(16'h0080, 1'b0);
        push_cfg(ORDER_L1);
        push_sample(16'h0040, 1'b1);

        vec_no = 0;
        while (item_total < ITEM_TARGET) begin
            if (vec_no == 4) begin
                len = MAX_LEN;
            end else if (vec_no == 11) begin
                len = MAX_LEN + 3;
            end else begin
                len = $urandom_range(1, 12);
            end
            zero_vec = ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 99) < 30) begin
                push_cfg($urandom_range(0, 1));
            end
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 99) < 5) begin
                    push_cfg($urandom_range(0, 1));
                end
                push_sample(zero_vec ? 16'h0000 : random_sample(), k == len - 1);
            end
            vec_no++;
        end
        push_cfg(ORDER_L2);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (send_queue.size() != 0 || in_valid_r || norm_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d vectors (%0d L1, %0d L2) with %0d samples dropped past the length",
                 vectors_l1 + vectors_l2, vectors_l1, vectors_l2, dropped_cnt);
        $display("limit, and checked %0d normalized output transfers.", results_seen);
        if (err_cnt == 0) begin
            $display("[lp_vector_normalizer] OK");
        end else begin
            $display("%0d failures in total.", err_cnt);
            $display("[lp_vector_normalizer] ERROR");
        end
        $finish;
    end

    // Input side and configuration writes; a write waits until no results are outstanding and the block has settled.
    always @(posedge i_clk) begin : drive_proc
        logic        nxt_valid;
        t_in_item    nxt_data;
        logic        nxt_we;
        logic        nxt_wdata;
        t_send_entry entry;
        nxt_valid = in_valid_r;
        nxt_data  = in_data_r;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata_r;
        if (!i_rst_n) begin
            nxt_valid  = 1'b0;
            settle_cnt = 0;
        end else begin
            if ((in_valid_r && o_in_ready) || (o_out_valid && out_ready_r)) begin
                settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
            end
            if (in_valid_r && o_in_ready) begin
                predict_vector_step(in_data_r);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && send_queue.size() > 0) begin
                if (send_queue[0].is_cfg) begin
                    if (norm_results_q.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
                        entry      = send_queue.pop_front();
                        nxt_we     = 1'b1;
                        nxt_wdata  = entry.cfg_val;
                        order_copy = entry.cfg_val;
                        settle_cnt = 0;
                        calm_r    <= entry.calm;
                    end
                end else if (send_queue[0].calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
                    entry     = send_queue.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = entry.item;
                    calm_r   <= entry.calm;
                end
            end
        end
        in_valid_r  <= nxt_valid;
        in_data_r   <= nxt_data;
        cfg_we_r    <= nxt_we;
        cfg_wdata_r <= nxt_wdata;
    end

    // Output side: random backpressure outside the calm stretch and comparison against the oldest expectation.
    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        if (!i_rst_n) begin
            out_ready_r <= 1'b0;
        end else begin
            if (o_out_valid && out_ready_r) begin
                results_seen++;
                if (norm_results_q.size() == 0) begin
                    note_failure($sformatf("unexpected transfer normalized=%0d last_out=%0b",
                                           o_out_data.normalized, o_out_data.last_out));
                end else begin
                    want = norm_results_q.pop_front();
                    if (o_out_data.normalized !== want.normalized ||
                        o_out_data.last_out !== want.last_out) begin
                        note_failure($sformatf(
                            "mismatch: expected normalized=%0d last_out=%0b, got %0d %0b",
                            want.normalized, want.last_out,
                            o_out_data.normalized, o_out_data.last_out));
                    end
                end
            end
            out_ready_r <= calm_r || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (in_valid_r && o_in_ready) || (o_out_valid && out_ready_r)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("No transfer for %0d cycles with %0d results outstanding.",
                         stall_cycles, norm_results_q.size());
                $display("[lp_vector_normalizer] ERROR");
                $finish;
            end
        end
    end

endmodule
